// ----- src/sas_pkg.sv -----
`default_nettype none

package sas_pkg;

    localparam int NUM_ANIMS_DEF   = 16;
    localparam int MAX_STAGES_DEF  = 16;
    localparam int COORD_BITS_DEF  = 8;
    localparam int PERIOD_BITS_DEF = 8;

    // Depth of the result queue; a power of two.
    localparam int OUT_DEPTH = 4;

    typedef enum logic [1:0] {
        FN_TICK       = 2'd0,
        FN_SELECT     = 2'd1,
        FN_LOAD_COORD = 2'd2,
        FN_LOAD_COUNT = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [3:0]  anim_id;
        logic        loop_flag;
        logic        keep_speed;
        logic [7:0]  ticks_per_frame;
        logic        force_req;
        logic [3:0]  stage_index;
        logic [4:0]  stage_count;
        logic [7:0]  load_x;
        logic [7:0]  load_y;
    } t_in;

    typedef struct packed {
        logic [7:0]  frame_x;
        logic [7:0]  frame_y;
        logic [3:0]  playing_anim;
        logic [3:0]  playing_stage;
    } t_out;

endpackage

`default_nettype wire

// ----- src/sprite_animation_sequencer.sv -----
// Sprite animation sequencer.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is a tick, a
// select request, a frame coordinate load or a frame count load. Output channel
// (o_out_valid / i_out_ready / o_out_data): one transaction per tick that shows a
// frame, carrying the sheet coordinate, the animation and the frame position.
// Throughput: one input transaction per cycle while the result queue has room. The per-animation frame position
// lives in a small RAM read in the accept cycle and written back by the execute
// stage; a same-entry write in that cycle is forwarded. The one exception is a
// looping animation whose stored position lies beyond a reloaded frame count: the
// wrap is then found by repeated subtraction, one step per cycle, holding the
// input until the wrap is done. A tick is executed and its frame table read
// registered, then its result is written into the result queue.
// When the receiver stalls, results collect in a four-entry queue; o_in_ready drops
// as soon as the queue plus the transactions still in flight could fill it.
// Reset (synchronous, active low) clears the playback state and marks every frame
// position as zero; the frame tables hold garbage until loaded.
`default_nettype none

module sprite_animation_sequencer #(
    parameter int NUM_ANIMS   = sas_pkg::NUM_ANIMS_DEF,
    parameter int MAX_STAGES  = sas_pkg::MAX_STAGES_DEF,
    parameter int COORD_BITS  = sas_pkg::COORD_BITS_DEF,
    parameter int PERIOD_BITS = sas_pkg::PERIOD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sas_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sas_pkg::t_out o_out_data
);
    import sas_pkg::*;

    localparam int AW         = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int SW         = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int TOT_W      = $clog2(MAX_STAGES + 1);
    localparam int TABLE_SIZE = NUM_ANIMS * MAX_STAGES;
    localparam int FT_W       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int FW         = 2 * COORD_BITS;
    localparam int PTR_W      = $clog2(OUT_DEPTH);
    localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

    // Playback state
    logic                   r_has_anim;
    logic [AW-1:0]          r_playing, n_playing;
    logic [AW-1:0]          r_queued, n_queued;
    logic                   r_looping, n_looping;
    logic                   r_q_looping, n_q_looping;
    logic [PERIOD_BITS-1:0] r_period, n_period;
    logic [PERIOD_BITS-1:0] r_q_period, n_q_period;
    logic [PERIOD_BITS-1:0] r_tick_count, n_tick_count;
    logic                   n_has_anim;

    // Execute stage
    logic                   r_ex_vld;
    t_in                    r_ex;

    // Frame position RAM: two read ports, one write port, valid bits for reset
    logic [SW-1:0]          r_pos_mem [NUM_ANIMS];
    logic [NUM_ANIMS-1:0]   r_pos_vld;
    logic [SW-1:0]          r_pa_d, r_pb_d, r_pw_d;
    logic                   r_pa_v, r_pb_v, r_pa_fw, r_pb_fw;

    // Frame count RAM
    logic [4:0]             r_tot_mem [NUM_ANIMS];
    logic [4:0]             r_t_d, r_tw_d;
    logic                   r_t_fw;

    // Frame coordinate RAM
    logic [FW-1:0]          r_frame_mem [TABLE_SIZE];
    logic [FW-1:0]          r_fr_d;
    logic                   r_rd_vld;
    logic [3:0]             r_rd_anim, r_rd_stage;

    // Wrap unit for stale positions
    logic                   r_div_busy;
    logic [TOT_W-1:0]       r_rem;

    // Result queue
    t_out                   r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]       r_cnt;

    // Execute datapath
    logic                   anim_ok, stage_ok;
    logic [AW-1:0]          ex_anim;
    logic [SW-1:0]          st, qst, out_stage;
    logic [4:0]             traw;
    logic [TOT_W-1:0]       tot, st1;
    logic                   last, do_switch, stale_mod, ex_done, emit;
    logic [PERIOD_BITS-1:0] per, tc1;
    logic                   pos_we, tot_we, fr_we;
    logic [AW-1:0]          pos_wa, tot_wa;
    logic [SW-1:0]          pos_wd;
    logic [4:0]             tot_wd;
    logic [FT_W-1:0]        fr_wa, ft_ra;
    logic [FW-1:0]          fr_wd;
    logic                   accept, push, pop;

    always_comb begin
        ex_anim  = AW'(r_ex.anim_id);
        anim_ok  = ({28'd0, r_ex.anim_id} < 32'(NUM_ANIMS));
        stage_ok = ({28'd0, r_ex.stage_index} < 32'(MAX_STAGES));

        // Forward a same-edge write-back, else read data, else reset value
        st   = r_pa_fw ? r_pw_d : (r_pa_v ? r_pa_d : '0);
        qst  = r_pb_fw ? r_pw_d : (r_pb_v ? r_pb_d : '0);
        traw = r_t_fw ? r_tw_d : r_t_d;

        // Clamp the stored frame count to 1..MAX_STAGES
        if (traw == 5'd0) begin
            tot = TOT_W'(1);
        end else if ({27'd0, traw} > 32'(MAX_STAGES)) begin
            tot = TOT_W'(MAX_STAGES);
        end else begin
            tot = TOT_W'(traw);
        end

        st1       = TOT_W'(st) + TOT_W'(1);
        last      = (st1 == tot);
        do_switch = (r_playing != r_queued) && last;
        stale_mod = r_ex_vld && (r_ex.func == FN_TICK) && r_has_anim &&
                    (r_tick_count == '0) && !do_switch && r_looping && (st1 > tot);
        ex_done   = r_ex_vld && (!stale_mod || (r_div_busy && (r_rem < tot)));

        n_has_anim   = r_has_anim;
        n_playing    = r_playing;
        n_queued     = r_queued;
        n_looping    = r_looping;
        n_q_looping  = r_q_looping;
        n_period     = r_period;
        n_q_period   = r_q_period;
        n_tick_count = r_tick_count;
        per          = r_ex.keep_speed ? r_period : PERIOD_BITS'(r_ex.ticks_per_frame);
        tc1          = '0;
        pos_we       = 1'b0;
        pos_wa       = r_playing;
        pos_wd       = '0;
        tot_we       = 1'b0;
        tot_wa       = ex_anim;
        tot_wd       = r_ex.stage_count;
        fr_we        = 1'b0;
        fr_wa        = FT_W'(32'(ex_anim) * 32'(MAX_STAGES) + 32'(r_ex.stage_index));
        fr_wd        = {COORD_BITS'(r_ex.load_x), COORD_BITS'(r_ex.load_y)};
        emit         = 1'b0;
        out_stage    = st;

        if (ex_done) begin
            unique case (r_ex.func)
                FN_TICK: begin
                    if (r_has_anim) begin
                        if (r_tick_count == '0) begin
                            emit = 1'b1;
                            if (do_switch) begin
                                // Hand over to the queued animation
                                pos_we      = 1'b1;
                                pos_wd      = '0;
                                n_playing   = r_queued;
                                n_looping   = r_q_looping;
                                n_period    = r_q_period;
                                out_stage   = qst;
                            end else if (r_looping || (st1 < tot)) begin
                                pos_we = 1'b1;
                                if (stale_mod) begin
                                    pos_wd = SW'(r_rem);
                                end else if (last) begin
                                    pos_wd = '0;
                                end else begin
                                    pos_wd = SW'(st1);
                                end
                                out_stage = pos_wd;
                            end
                        end
                        tc1          = r_tick_count + PERIOD_BITS'(1);
                        n_tick_count = (tc1 >= n_period) ? '0 : tc1;
                    end
                end
                FN_SELECT: begin
                    if (anim_ok) begin
                        if (!r_has_anim || (ex_anim == r_playing) || r_ex.force_req) begin
                            n_has_anim = 1'b1;
                            n_playing  = ex_anim;
                            n_queued   = ex_anim;
                            n_looping  = r_ex.loop_flag;
                            n_period   = per;
                            pos_we     = 1'b1;
                            pos_wa     = ex_anim;
                            pos_wd     = '0;
                        end else begin
                            n_queued    = ex_anim;
                            n_q_looping = r_ex.loop_flag;
                            n_q_period  = per;
                        end
                    end
                end
                FN_LOAD_COORD: begin
                    fr_we = anim_ok && stage_ok;
                end
                FN_LOAD_COUNT: begin
                    tot_we = anim_ok;
                end
                default: begin
                end
            endcase
        end

        ft_ra = FT_W'(32'(n_playing) * 32'(MAX_STAGES) + 32'(out_stage));
    end

    // Hold input while the execute stage is busy or the queue could overflow
    assign o_in_ready = (!r_ex_vld || ex_done) &&
                        ((32'(r_cnt) + 32'(r_ex_vld) + 32'(r_rd_vld)) < 32'(OUT_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    // Control and playback state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_anim   <= 1'b0;
            r_playing    <= '0;
            r_queued     <= '0;
            r_looping    <= 1'b0;
            r_q_looping  <= 1'b0;
            r_period     <= PERIOD_BITS'(1);
            r_q_period   <= PERIOD_BITS'(1);
            r_tick_count <= '0;
            r_ex_vld     <= 1'b0;
            r_pos_vld    <= '0;
            r_div_busy   <= 1'b0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_has_anim   <= n_has_anim;
            r_playing    <= n_playing;
            r_queued     <= n_queued;
            r_looping    <= n_looping;
            r_q_looping  <= n_q_looping;
            r_period     <= n_period;
            r_q_period   <= n_q_period;
            r_tick_count <= n_tick_count;
            if (accept) begin
                r_ex_vld <= 1'b1;
            end else if (ex_done) begin
                r_ex_vld <= 1'b0;
            end
            if (pos_we) begin
                r_pos_vld[pos_wa] <= 1'b1;
            end
            // Wrap unit: subtract the frame count until the position fits
            if (stale_mod && !r_div_busy) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && (r_rem < tot)) begin
                r_div_busy <= 1'b0;
            end
            r_rd_vld <= ex_done && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex <= i_in_data;
        end
        if (stale_mod && !r_div_busy) begin
            r_rem <= st1;
        end else if (r_div_busy && (r_rem >= tot)) begin
            r_rem <= r_rem - tot;
        end
    end

    // Frame position RAM; reads address the state after the executing transaction
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= pos_wd;
        end
        r_pa_d  <= r_pos_mem[n_playing];
        r_pb_d  <= r_pos_mem[n_queued];
        r_pa_v  <= r_pos_vld[n_playing];
        r_pb_v  <= r_pos_vld[n_queued];
        r_pa_fw <= pos_we && (pos_wa == n_playing);
        r_pb_fw <= pos_we && (pos_wa == n_queued);
        r_pw_d  <= pos_wd;
    end

    // Frame count RAM
    always_ff @(posedge i_clk) begin
        if (tot_we) begin
            r_tot_mem[tot_wa] <= tot_wd;
        end
        r_t_d  <= r_tot_mem[n_playing];
        r_t_fw <= tot_we && (tot_wa == n_playing);
        r_tw_d <= tot_wd;
    end

    // Frame coordinate RAM
    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_frame_mem[fr_wa] <= fr_wd;
        end
        r_fr_d     <= r_frame_mem[ft_ra];
        r_rd_anim  <= 4'(n_playing);
        r_rd_stage <= 4'(out_stage);
    end

    // Result queue
    assign push        = r_rd_vld;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{
                frame_x:       8'(r_fr_d[FW-1:COORD_BITS]),
                frame_y:       8'(r_fr_d[COORD_BITS-1:0]),
                playing_anim:  r_rd_anim,
                playing_stage: r_rd_stage
            };
        end
    end

endmodule

`default_nettype wire
